[rtl/lru_page_cache_lookup_top_assert.svh]
// Assertion macros used by the checker file of the page cache.
`ifndef LRU_PAGE_CACHE_LOOKUP_TOP_ASSERT_SVH
`define LRU_PAGE_CACHE_LOOKUP_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPCL_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define LPCL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/lpcl_pkg.sv]
package lpcl_pkg;

  // Fixed widths of the configuration register and the result fields.
  localparam int LIMIT_W   = 9;
  localparam int SLOT_W    = 8;
  localparam int OUT_KEY_W = 64;

endpackage

[rtl/lpcl_ram.sv]
module lpcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/lru_page_cache_lookup_top.sv]
// An item runs from acceptance to its result through the sequencer states; the key memory
// is scanned one slot per cycle over the filled slots, and a result that finds the
// previous one still waiting in the output register stalls until it is taken.
// Throughput: one item at a time; the next item is taken once the result is registered,
// even while that result still waits to be taken.
// Reset (synchronous, active high) empties the cache and sets the slot limit to 256.
// The memories are not cleared; the fill count keeps unwritten slots out of every search.
module lru_page_cache_lookup_top
  import lpcl_pkg::*;
#(
  parameter int SLOTS    = 256,
  parameter int KEY_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 slot_limit_we,
  input  logic [LIMIT_W-1:0]   slot_limit,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OUT_KEY_W-1:0] key,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 hit,
  output logic [SLOT_W-1:0]    slot,
  output logic                 evicted,
  output logic [OUT_KEY_W-1:0] evicted_key
);

  localparam int IW   = $clog2(SLOTS);
  localparam int CW   = $clog2(SLOTS + 1);
  localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;

  // The sequencer walks each item through a subset of these states. SCAN compares one
  // stored key per cycle, MISS chooses between filling a free slot and
  // replacing the oldest one, LINK and LWR2 rewrite the recency links, and
  // DONE hands the result to the output register.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MISS,
    ST_LINK,
    ST_LWR2,
    ST_DONE
  } state_t;

  state_t state;

  logic [LIMIT_W-1:0]  cur_limit;
  logic [CW-1:0]       fill_count;
  logic [IW-1:0]       newest_slot;
  logic [IW-1:0]       oldest_slot;
  logic [IW-1:0]       chk;
  logic [KEY_BITS-1:0] key_r;
  logic                hit_r;
  logic                evict_r;
  logic [KEY_BITS-1:0] oldkey_r;
  logic [IW-1:0]       s_r;

  // Memory ports. Keys sit in one memory, the two link directions in two more.
  logic                key_we;
  logic [IW-1:0]       key_waddr;
  logic [IW-1:0]       key_raddr;
  logic [KEY_BITS-1:0] key_rdata;
  logic                nw_we;
  logic [IW-1:0]       nw_waddr;
  logic [IW-1:0]       nw_wdata;
  logic [IW-1:0]       nw_raddr;
  logic [IW-1:0]       nw_rdata;
  logic                ol_we;
  logic [IW-1:0]       ol_waddr;
  logic [IW-1:0]       ol_wdata;
  logic [IW-1:0]       ol_raddr;
  logic [IW-1:0]       ol_rdata;

  logic          key_match;
  logic          scan_last;
  logic          cache_full;
  logic          room;
  logic [IW-1:0] fill_slot;

  assign in_ready  = (state == ST_IDLE);
  assign key_match = (key_rdata == key_r);
  assign scan_last = ((CW'(chk) + CW'(1)) == fill_count);
  assign fill_slot = IW'(fill_count);

  // A new slot may be filled while fewer than the effective limit are used.
  // A programmed limit of zero acts as one, and a limit above the slot
  // count is capped by the physical size of the cache.
  assign cache_full = (fill_count == CW'(SLOTS));
  assign room = !cache_full &&
                ((fill_count == '0) || (CMPW'(fill_count) < CMPW'(cur_limit)));

  lpcl_ram #(.WIDTH(KEY_BITS), .DEPTH(SLOTS)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_r),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  lpcl_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_newer_ram (
    .clk   (clk),
    .we    (nw_we),
    .waddr (nw_waddr),
    .wdata (nw_wdata),
    .raddr (nw_raddr),
    .rdata (nw_rdata)
  );

  lpcl_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_older_ram (
    .clk   (clk),
    .we    (ol_we),
    .waddr (ol_waddr),
    .wdata (ol_wdata),
    .raddr (ol_raddr),
    .rdata (ol_rdata)
  );

  // Memory addressing. Reads are issued in the state before the one that
  // consumes them; writes of one item finish before the next item reads,
  // so no forwarding is needed.
  always_comb begin
    key_we    = 1'b0;
    key_waddr = s_r;
    key_raddr = '0;
    nw_we     = 1'b0;
    nw_waddr  = newest_slot;
    nw_wdata  = s_r;
    nw_raddr  = s_r;
    ol_we     = 1'b0;
    ol_waddr  = s_r;
    ol_wdata  = newest_slot;
    ol_raddr  = s_r;
    unique case (state)
      ST_IDLE: begin
        key_raddr = '0;
      end
      ST_SCAN: begin
        key_raddr = chk + IW'(1);
        nw_raddr  = chk;
        ol_raddr  = chk;
      end
      ST_MISS: begin
        key_raddr = oldest_slot;
        nw_raddr  = oldest_slot;
        ol_raddr  = oldest_slot;
        if (room) begin
          key_we    = 1'b1;
          key_waddr = fill_slot;
          if (fill_count != '0) begin
            ol_we    = 1'b1;
            ol_waddr = fill_slot;
            ol_wdata = newest_slot;
            nw_we    = 1'b1;
            nw_waddr = newest_slot;
            nw_wdata = fill_slot;
          end
        end
      end
      ST_LINK: begin
        key_we = evict_r;
        if (s_r == newest_slot) begin
          // Already the newest entry: the list stays as it is.
        end else if (s_r == oldest_slot) begin
          ol_we = 1'b1;
          nw_we = 1'b1;
        end else begin
          // Unlink the slot from between its two neighbors.
          nw_we    = 1'b1;
          nw_waddr = ol_rdata;
          nw_wdata = nw_rdata;
          ol_we    = 1'b1;
          ol_waddr = nw_rdata;
          ol_wdata = ol_rdata;
        end
      end
      ST_LWR2: begin
        ol_we = 1'b1;
        nw_we = 1'b1;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cur_limit   <= LIMIT_W'(256);
      fill_count  <= '0;
      newest_slot <= '0;
      oldest_slot <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (slot_limit_we) begin
        cur_limit <= slot_limit;
      end
      // In DONE the output register is reloaded below instead.
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            key_r <= key[KEY_BITS-1:0];
            chk   <= '0;
            state <= (fill_count == '0) ? ST_MISS : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (key_match) begin
            hit_r   <= 1'b1;
            evict_r <= 1'b0;
            s_r     <= chk;
            state   <= ST_LINK;
          end else if (scan_last) begin
            state <= ST_MISS;
          end else begin
            chk <= chk + IW'(1);
          end
        end
        ST_MISS: begin
          hit_r <= 1'b0;
          if (room) begin
            s_r         <= fill_slot;
            evict_r     <= 1'b0;
            oldkey_r    <= '0;
            newest_slot <= fill_slot;
            if (fill_count == '0) begin
              oldest_slot <= fill_slot;
            end
            fill_count <= fill_count + CW'(1);
            state      <= ST_DONE;
          end else begin
            s_r     <= oldest_slot;
            evict_r <= 1'b1;
            state   <= ST_LINK;
          end
        end
        ST_LINK: begin
          oldkey_r <= evict_r ? key_rdata : '0;
          if (s_r == newest_slot) begin
            state <= ST_DONE;
          end else if (s_r == oldest_slot) begin
            oldest_slot <= nw_rdata;
            newest_slot <= s_r;
            state       <= ST_DONE;
          end else begin
            state <= ST_LWR2;
          end
        end
        ST_LWR2: begin
          newest_slot <= s_r;
          state       <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            hit         <= hit_r;
            slot        <= SLOT_W'(s_r);
            evicted     <= evict_r;
            evicted_key <= OUT_KEY_W'(oldkey_r);
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/lpcl_checker.sv]
module lpcl_checker
  import lpcl_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 hit,
  input logic [SLOT_W-1:0]    slot,
  input logic                 evicted,
  input logic [OUT_KEY_W-1:0] evicted_key
);

  `include "lru_page_cache_lookup_top_assert.svh"

  // A replacement only happens on a miss.
  `LPCL_ASSERT_SAME(a_evict_is_miss, out_valid && evicted, !hit)

  // Without a replacement no key is reported.
  `LPCL_ASSERT_SAME(a_no_evict_zero_key, out_valid && !evicted, evicted_key == '0)

  // The block works on one item at a time.
  `LPCL_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)

  // A stalled result holds.
  `LPCL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(slot))

endmodule

bind lru_page_cache_lookup_top lpcl_checker u_lpcl_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .hit         (hit),
  .slot        (slot),
  .evicted     (evicted),
  .evicted_key (evicted_key)
);
